// ===== design/utf8_decoder_6byte_validating_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODER_6BYTE_VALIDATING_ASSERT_SVH
`define UTF8_DECODER_6BYTE_VALIDATING_ASSERT_SVH

// Same-cycle implication.
`define U8D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("u8d assertion failed");

// Next-cycle implication.
`define U8D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("u8d assertion failed");

`endif

// ===== design/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Item types, status codes and length limits shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2,
        ST_OVERLONG = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [7:0] byte_4;
        logic [7:0] byte_5;
    } t_u8d_in;

    typedef struct packed {
        logic [30:0] code_point;
        t_status     status;
        logic [2:0]  consumed;
        logic [2:0]  error_offset;
    } t_u8d_out;

    // Largest value the next shorter form can carry; a value at or below it
    // is overlong for a sequence with this many continuation bytes.
    function automatic logic [30:0] u8d_short_max(input logic [2:0] extra);
        logic [30:0] v;
        case (extra)
            3'd1: v = 31'h0000007f;
            3'd2: v = 31'h000007ff;
            3'd3: v = 31'h0000ffff;
            3'd4: v = 31'h001fffff;
            3'd5: v = 31'h03ffffff;
            default: v = 31'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/u8d_assemble.sv =====
// ----------------------------------------------------------------------------
// UTF-8 payload assembly
// Joins the lead byte's payload bits with six bits from each continuation.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_assemble
    import u8d_pkg::*;
(
    input  t_u8d_in     i_bytes,
    input  logic [2:0]  i_extra,
    output logic [30:0] o_value
);

    always_comb begin
        case (i_extra)
            3'd1: o_value = {20'd0, i_bytes.byte_0[4:0], i_bytes.byte_1[5:0]};
            3'd2: o_value = {15'd0, i_bytes.byte_0[3:0], i_bytes.byte_1[5:0],
                             i_bytes.byte_2[5:0]};
            3'd3: o_value = {10'd0, i_bytes.byte_0[2:0], i_bytes.byte_1[5:0],
                             i_bytes.byte_2[5:0], i_bytes.byte_3[5:0]};
            3'd4: o_value = {5'd0, i_bytes.byte_0[1:0], i_bytes.byte_1[5:0],
                             i_bytes.byte_2[5:0], i_bytes.byte_3[5:0],
                             i_bytes.byte_4[5:0]};
            3'd5: o_value = {i_bytes.byte_0[0], i_bytes.byte_1[5:0],
                             i_bytes.byte_2[5:0], i_bytes.byte_3[5:0],
                             i_bytes.byte_4[5:0], i_bytes.byte_5[5:0]};
            default: o_value = {23'd0, i_bytes.byte_0};
        endcase
    end

endmodule

`default_nettype wire

// ===== design/utf8_decoder_6byte_validating.sv =====
// The result strobe o_valid is raised from the stage 3 valid bit once the item has passed every stage.
// Throughput: one item per cycle; busy stays low, so start may be held high.
// Three register stages: lead classification, payload assembly with the
// continuation check, then the overlong compare into the output register.
// Synchronous active-low reset clears the stage valid bits; no results follow.
// ----------------------------------------------------------------------------
// UTF-8 six-byte validating decoder
// Decodes one one-to-six byte sequence of the 31-bit form per item.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decoder_6byte_validating
    import u8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_u8d_in  i_item,
    output logic     busy,
    output logic     o_valid,
    output t_u8d_out o_result
);

    `include "utf8_decoder_6byte_validating_assert.svh"

    // Stage 1: lead byte classification and continuation form per byte.
    logic       r_v1;
    t_u8d_in    r_bytes1;
    logic [2:0] r_ones1;
    logic [5:1] r_cont1;
    logic [2:0] n_ones1;
    logic [5:1] n_cont1;

    // Stage 2: assembled value and lead or continuation errors.
    logic        r_v2;
    logic [30:0] r_val2;
    t_status     r_st2;
    logic [2:0]  r_off2;
    logic [2:0]  r_extra2;
    logic        r_chk2;
    logic [2:0]  n_extra2;
    logic [30:0] n_val2;
    t_status     n_st2;
    logic [2:0]  n_off2;
    logic        n_chk2;

    // Stage 3: output register.
    logic     r_v3;
    t_u8d_out r_res3;
    t_u8d_out n_res3;

    assign busy = 1'b0;

    // Count of leading ones in the lead byte; seven stands for seven or eight.
    always_comb begin
        if (!i_item.byte_0[7]) begin
            n_ones1 = 3'd0;
        end else if (!i_item.byte_0[6]) begin
            n_ones1 = 3'd1;
        end else if (!i_item.byte_0[5]) begin
            n_ones1 = 3'd2;
        end else if (!i_item.byte_0[4]) begin
            n_ones1 = 3'd3;
        end else if (!i_item.byte_0[3]) begin
            n_ones1 = 3'd4;
        end else if (!i_item.byte_0[2]) begin
            n_ones1 = 3'd5;
        end else if (!i_item.byte_0[1]) begin
            n_ones1 = 3'd6;
        end else begin
            n_ones1 = 3'd7;
        end
        n_cont1[1] = (i_item.byte_1[7:6] == 2'b10);
        n_cont1[2] = (i_item.byte_2[7:6] == 2'b10);
        n_cont1[3] = (i_item.byte_3[7:6] == 2'b10);
        n_cont1[4] = (i_item.byte_4[7:6] == 2'b10);
        n_cont1[5] = (i_item.byte_5[7:6] == 2'b10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
        r_bytes1 <= i_item;
        r_ones1  <= n_ones1;
        r_cont1  <= n_cont1;
    end

    assign n_extra2 = r_ones1 - 3'd1;

    u8d_assemble u_assemble (
        .i_bytes (r_bytes1),
        .i_extra ((r_ones1 == 3'd0) ? 3'd0 : n_extra2),
        .o_value (n_val2)
    );

    always_comb begin
        logic found;
        found  = 1'b0;
        n_st2  = ST_OK;
        n_off2 = 3'd0;
        n_chk2 = 1'b0;
        if (r_ones1 == 3'd0) begin
            n_st2 = ST_OK;
        end else if (r_ones1 == 3'd1 || r_ones1 == 3'd7) begin
            n_st2 = ST_BAD_LEAD;
        end else begin
            n_chk2 = 1'b1;
            // The first malformed continuation in byte order is reported.
            for (int k = 1; k <= 5; k++) begin
                if (!found && (3'(k) <= n_extra2) && !r_cont1[3'(k)]) begin
                    found  = 1'b1;
                    n_st2  = ST_BAD_CONT;
                    n_off2 = 3'(k);
                    n_chk2 = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_val2   <= n_val2;
        r_st2    <= n_st2;
        r_off2   <= n_off2;
        r_extra2 <= n_extra2;
        r_chk2   <= n_chk2;
    end

    always_comb begin
        n_res3 = '0;
        if (r_st2 != ST_OK) begin
            n_res3.status       = r_st2;
            n_res3.error_offset = r_off2;
        end else if (r_chk2 && (r_val2 <= u8d_short_max(r_extra2))) begin
            n_res3.status       = ST_OVERLONG;
            n_res3.error_offset = r_extra2 + 3'd1;
        end else begin
            n_res3.code_point = r_val2;
            n_res3.status     = ST_OK;
            n_res3.consumed   = r_chk2 ? (r_extra2 + 3'd1) : 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_res3 <= n_res3;
    end

    assign o_valid  = r_v3;
    assign o_result = r_res3;

    `U8D_ASSERT_NOW(a_latency,
        $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3),
        o_valid == $past(start, 3))
    `U8D_ASSERT_NOW(a_ok_fields,
        o_valid && o_result.status == ST_OK,
        o_result.consumed != 3'd0 && o_result.error_offset == 3'd0)
    `U8D_ASSERT_NOW(a_err_fields,
        o_valid && o_result.status != ST_OK,
        o_result.code_point == 31'd0 && o_result.consumed == 3'd0)
    `U8D_ASSERT_NEXT(a_overlong_off,
        r_v2 && r_st2 == ST_OK && r_chk2,
        o_result.status == ST_OK || o_result.error_offset >= 3'd2)

endmodule

`default_nettype wire
